[sv/enfr_pkg.sv]
// ----------------------------------------------------------------------------
// ECEF / NED frame rotation package
// Widths, register indexes, request codes and payload types shared by the
// frame rotation pipeline.
// ----------------------------------------------------------------------------
package enfr_pkg;

	localparam int COORD_WIDTH    = 35;
	localparam int TRIG_FRAC_BITS = 30;
	localparam int TRIG_WIDTH     = 32;

	// Configuration port geometry.
	localparam bit CFG_WIDE = (COORD_WIDTH > 32);
	localparam int DATA_W   = CFG_WIDE ? 64 : 32;
	localparam int ADDR_LSB = CFG_WIDE ? 3 : 2;
	localparam int IDX_W    = 3;
	localparam int ADDR_W   = ADDR_LSB + IDX_W;

	// Datapath widths.
	localparam int MENT_W = TRIG_FRAC_BITS + 2;
	localparam int MP_W   = 2 * MENT_W;
	localparam int VEC_W  = COORD_WIDTH + 1;
	localparam int LO_W   = VEC_W / 2;
	localparam int HI_W   = VEC_W - LO_W;
	localparam int PH_W   = MENT_W + HI_W;
	localparam int PL_W   = MENT_W + LO_W + 1;
	localparam int P_W    = MENT_W + VEC_W;
	localparam int S_W    = P_W + 2;
	localparam int DOT_W  = S_W - TRIG_FRAC_BITS;
	localparam int RES_W  = DOT_W + 1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [TRIG_WIDTH-1:0]  trig_t;
	typedef logic signed [MENT_W-1:0]      ment_t;
	typedef logic signed [MP_W-1:0]        mprod_t;
	typedef logic signed [VEC_W-1:0]       vec_t;
	typedef logic signed [PH_W-1:0]        ph_t;
	typedef logic signed [PL_W-1:0]        pl_t;
	typedef logic signed [P_W-1:0]         prod_t;
	typedef logic signed [S_W-1:0]         sum_t;
	typedef logic signed [DOT_W-1:0]       dot_t;
	typedef logic signed [RES_W-1:0]       res_t;

	localparam trig_t  TRIG_ONE     = TRIG_WIDTH'(64'd1 << TRIG_FRAC_BITS);
	localparam trig_t  TRIG_RST_ONE = 32'sd1073741824;
	localparam mprod_t MP_HALF      = MP_W'(128'd1 << (TRIG_FRAC_BITS - 1));
	localparam sum_t   S_HALF       = S_W'(128'd1 << (TRIG_FRAC_BITS - 1));
	localparam coord_t COORD_MAX    = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
	localparam coord_t COORD_MIN    = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

	typedef enum logic [IDX_W-1:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_SIN_LAT  = 3'd3,
		REG_COS_LAT  = 3'd4,
		REG_SIN_LON  = 3'd5,
		REG_COS_LON  = 3'd6
	} reg_idx_t;

	typedef enum logic {
		REQ_ECEF_TO_NED = 1'b0,
		REQ_NED_TO_ECEF = 1'b1
	} req_t;

endpackage

[sv/ecef_ned_frame_rotation.sv]
// ----------------------------------------------------------------------------
// ECEF / NED frame rotation
// Converts positions between Earth-centered coordinates and a local
// north-east-down frame about a loaded reference origin, in a fixed-point
// pipeline.
// ----------------------------------------------------------------------------
// Usage:
// The reference origin and the sines and cosines of the reference latitude
// and longitude are loaded through the APB port, one 64-bit register every
// 8 bytes; the user must do so while no item is in flight, as the block does
// not enforce it. pready is always high. An item is taken at each clock edge
// where start is high and busy is low. busy is never raised, so one item can
// be taken in every cycle. Each item passes through the seven-stage pipeline:
// the result sits on out_a, out_b, out_c and saturated for one cycle while
// done is high. In the multiply stage the 32 by 36 bit products are split in
// two halves, which are summed over the following stages.
// The receiver cannot hold results off, so nothing ever stalls inside.
// Reset clears the pipeline valid bits and loads the registers with a zero
// origin and a frame at zero latitude and longitude.
// ----------------------------------------------------------------------------
module ecef_ned_frame_rotation
	import enfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  logic              req_type,
	input  coord_t            coord_a,
	input  coord_t            coord_b,
	input  coord_t            coord_c,
	output logic              done,
	output coord_t            out_a,
	output coord_t            out_b,
	output coord_t            out_c,
	output logic              saturated
);

	function automatic ment_t trig_clamp(input trig_t t);
		ment_t r;
		if (t > TRIG_ONE) begin
			r = MENT_W'(TRIG_ONE);
		end else if (t < -TRIG_ONE) begin
			r = MENT_W'(-TRIG_ONE);
		end else begin
			r = MENT_W'(t);
		end
		return r;
	endfunction

	function automatic ment_t mp_round(input mprod_t v);
		mprod_t s;
		s = v + MP_HALF;
		return MENT_W'(s >>> TRIG_FRAC_BITS);
	endfunction

	// Configuration registers: trig order is sin_lat, cos_lat, sin_lon, cos_lon.
	coord_t   origin_q [3];
	trig_t    trig_q   [4];
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:ADDR_LSB]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q[0] <= '0;
			origin_q[1] <= '0;
			origin_q[2] <= '0;
			trig_q[0]   <= '0;
			trig_q[1]   <= TRIG_RST_ONE;
			trig_q[2]   <= '0;
			trig_q[3]   <= TRIG_RST_ONE;
		end else if (wr_en) begin
			unique case (idx)
				REG_ORIGIN_X: origin_q[0] <= coord_t'(pwdata[COORD_WIDTH-1:0]);
				REG_ORIGIN_Y: origin_q[1] <= coord_t'(pwdata[COORD_WIDTH-1:0]);
				REG_ORIGIN_Z: origin_q[2] <= coord_t'(pwdata[COORD_WIDTH-1:0]);
				REG_SIN_LAT:  trig_q[0]   <= trig_t'(pwdata[TRIG_WIDTH-1:0]);
				REG_COS_LAT:  trig_q[1]   <= trig_t'(pwdata[TRIG_WIDTH-1:0]);
				REG_SIN_LON:  trig_q[2]   <= trig_t'(pwdata[TRIG_WIDTH-1:0]);
				REG_COS_LON:  trig_q[3]   <= trig_t'(pwdata[TRIG_WIDTH-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ORIGIN_X: prdata = DATA_W'($unsigned(origin_q[0]));
			REG_ORIGIN_Y: prdata = DATA_W'($unsigned(origin_q[1]));
			REG_ORIGIN_Z: prdata = DATA_W'($unsigned(origin_q[2]));
			REG_SIN_LAT:  prdata = DATA_W'($unsigned(trig_q[0]));
			REG_COS_LAT:  prdata = DATA_W'($unsigned(trig_q[1]));
			REG_SIN_LON:  prdata = DATA_W'($unsigned(trig_q[2]));
			REG_COS_LON:  prdata = DATA_W'($unsigned(trig_q[3]));
			default:      prdata = '0;
		endcase
	end

	// Rotation matrix, rebuilt continuously from the registers.
	ment_t  tc [4];
	mprod_t mp_q [4];
	ment_t  mat [3][3];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			tc[k] = trig_clamp(trig_q[k]);
		end
	end

	always_ff @(posedge clk) begin
		mp_q[0] <= MP_W'(tc[0]) * MP_W'(tc[3]);
		mp_q[1] <= MP_W'(tc[0]) * MP_W'(tc[2]);
		mp_q[2] <= MP_W'(tc[1]) * MP_W'(tc[3]);
		mp_q[3] <= MP_W'(tc[1]) * MP_W'(tc[2]);
	end

	always_comb begin
		mat[0][0] = -mp_round(mp_q[0]);
		mat[0][1] = -mp_round(mp_q[1]);
		mat[0][2] = tc[1];
		mat[1][0] = -tc[2];
		mat[1][1] = tc[3];
		mat[1][2] = '0;
		mat[2][0] = mp_round(mp_q[2]);
		mat[2][1] = mp_round(mp_q[3]);
		mat[2][2] = tc[0];
	end

	// Item pipeline.
	logic   accept;
	logic   valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	req_t   type_s1, type_s2, type_s3, type_s4, type_s5, type_s6;
	coord_t c_s1 [3];
	vec_t   v_s2 [3];
	vec_t   v_s3 [3];
	ment_t  m_s3 [3][3];
	ph_t    ph_s4 [3][3];
	pl_t    pl_s4 [3][3];
	prod_t  p_s5 [3][3];
	sum_t   sum_s6 [3];
	coord_t res_s7 [3];
	logic   sat_s7;

	vec_t   v_d [3];
	ment_t  m_d [3][3];
	res_t   r_d [3];
	dot_t   dot_d [3];
	coord_t res_d [3];
	logic   sat_d;

	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (type_s1 == REQ_NED_TO_ECEF) begin
				v_d[i] = (i == 2) ? -VEC_W'(c_s1[i]) : VEC_W'(c_s1[i]);
			end else begin
				v_d[i] = VEC_W'(c_s1[i]) - VEC_W'(origin_q[i]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				m_d[i][j] = (type_s2 == REQ_NED_TO_ECEF) ? mat[j][i] : mat[i][j];
			end
		end
	end

	always_comb begin
		sat_d = 1'b0;
		for (int i = 0; i < 3; i++) begin
			dot_d[i] = DOT_W'(sum_s6[i] >>> TRIG_FRAC_BITS);
			if (type_s6 == REQ_NED_TO_ECEF) begin
				r_d[i] = RES_W'(dot_d[i]) + RES_W'(origin_q[i]);
			end else if (i == 2) begin
				r_d[i] = -RES_W'(dot_d[i]);
			end else begin
				r_d[i] = RES_W'(dot_d[i]);
			end
			if (r_d[i] > RES_W'(COORD_MAX)) begin
				res_d[i] = COORD_MAX;
				sat_d    = 1'b1;
			end else if (r_d[i] < RES_W'(COORD_MIN)) begin
				res_d[i] = COORD_MIN;
				sat_d    = 1'b1;
			end else begin
				res_d[i] = COORD_WIDTH'(r_d[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		type_s1 <= req_t'(req_type);
		c_s1[0] <= coord_a;
		c_s1[1] <= coord_b;
		c_s1[2] <= coord_c;
		type_s2 <= type_s1;
		type_s3 <= type_s2;
		type_s4 <= type_s3;
		type_s5 <= type_s4;
		type_s6 <= type_s5;
		for (int i = 0; i < 3; i++) begin
			v_s2[i]   <= v_d[i];
			v_s3[i]   <= v_s2[i];
			sum_s6[i] <= S_W'(p_s5[i][0]) + S_W'(p_s5[i][1]) + S_W'(p_s5[i][2]) + S_HALF;
			res_s7[i] <= res_d[i];
			for (int j = 0; j < 3; j++) begin
				m_s3[i][j]  <= m_d[i][j];
				ph_s4[i][j] <= PH_W'(m_s3[i][j]) * PH_W'($signed(v_s3[j][VEC_W-1:LO_W]));
				pl_s4[i][j] <= PL_W'(m_s3[i][j]) *
					PL_W'($signed({1'b0, v_s3[j][LO_W-1:0]}));
				p_s5[i][j]  <= (P_W'(ph_s4[i][j]) <<< LO_W) + P_W'(pl_s4[i][j]);
			end
		end
		sat_s7 <= sat_d;
	end

	assign done      = valid_s7;
	assign out_a     = res_s7[0];
	assign out_b     = res_s7[1];
	assign out_c     = res_s7[2];
	assign saturated = sat_s7;

endmodule

[dv/tb_ecef_ned_frame_rotation.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ECEF / NED frame rotation testbench
// Loads reference frames through the APB port and sends positions in both
// conversion directions. Each accepted item is predicted with exact wide
// integer arithmetic and compared field by field with the result that the
// pipeline returns. Frames range from realistic unit-norm rotations to
// out-of-range and extreme register values, and the sender idles at random.
// ----------------------------------------------------------------------------
module tb_ecef_ned_frame_rotation;
	import enfr_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		coord_t a;
		coord_t b;
		coord_t c;
		logic   sat;
	} position_t;

	localparam int          UNUSED_IDX  = 7;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          PRINT_LIMIT = 40;
	localparam int          FRAME_COUNT = 14;
	localparam int          FRAME_ITEMS = 100;
	localparam logic [63:0] COORD_MASK  = (64'd1 << COORD_WIDTH) - 64'd1;
	localparam logic [63:0] TRIG_MASK   = (64'd1 << TRIG_WIDTH) - 64'd1;
	localparam wide_t       HALF_LSB    = wide_t'(1) <<< (TRIG_FRAC_BITS - 1);
	localparam wide_t       UNIT        = wide_t'(1) <<< TRIG_FRAC_BITS;
	localparam wide_t       CLIP_HI     = COORD_MAX;
	localparam wide_t       CLIP_LO     = COORD_MIN;
	localparam real         EARTH_MM    = 6378137000.0;
	localparam real         DEG         = 3.14159265358979 / 180.0;

	logic              clk;
	logic              arst_n   = 1'b0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [DATA_W-1:0] pwdata   = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              start    = 1'b0;
	logic              busy;
	logic              req_type = 1'b0;
	coord_t            coord_a  = '0;
	coord_t            coord_b  = '0;
	coord_t            coord_c  = '0;
	logic              done;
	coord_t            out_a;
	coord_t            out_b;
	coord_t            out_c;
	logic              saturated;

	logic [63:0] frame_reg [7];
	position_t   pending [$];
	position_t   oldest;
	int          gap_limit       = 14;
	int          mismatches      = 0;
	int          items_sent      = 0;
	int          ecef_items      = 0;
	int          results_checked = 0;
	int          sat_results     = 0;
	int          frames_loaded   = 0;
	int unsigned cycle_count     = 0;

	ecef_ned_frame_rotation i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.coord_a(coord_a),
		.coord_b(coord_b),
		.coord_c(coord_c),
		.done(done),
		.out_a(out_a),
		.out_b(out_b),
		.out_c(out_c),
		.saturated(saturated)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ecef_ned_frame_rotation test failed");
		$finish;
	end

	function automatic wide_t round_frac(input wide_t v);
		return (v + HALF_LSB) >>> TRIG_FRAC_BITS;
	endfunction

	function automatic wide_t clamp_unit(input wide_t t);
		if (t > UNIT)
			return UNIT;
		if (t < -UNIT)
			return -UNIT;
		return t;
	endfunction

	function automatic position_t predict_position(input req_t req, input coord_t a, b, c);
		wide_t     sla, cla, slo, clo, acc;
		wide_t     rot [3][3];
		wide_t     org [3];
		wide_t     vec [3];
		wide_t     res [3];
		position_t p;
		sla = clamp_unit($signed(frame_reg[REG_SIN_LAT][TRIG_WIDTH-1:0]));
		cla = clamp_unit($signed(frame_reg[REG_COS_LAT][TRIG_WIDTH-1:0]));
		slo = clamp_unit($signed(frame_reg[REG_SIN_LON][TRIG_WIDTH-1:0]));
		clo = clamp_unit($signed(frame_reg[REG_COS_LON][TRIG_WIDTH-1:0]));
		rot[0][0] = -round_frac(sla * clo);
		rot[0][1] = -round_frac(sla * slo);
		rot[0][2] = cla;
		rot[1][0] = -slo;
		rot[1][1] = clo;
		rot[1][2] = '0;
		rot[2][0] = round_frac(cla * clo);
		rot[2][1] = round_frac(cla * slo);
		rot[2][2] = sla;
		for (int i = 0; i < 3; i++)
			org[i] = $signed(frame_reg[i][COORD_WIDTH-1:0]);
		vec[0] = a;
		vec[1] = b;
		vec[2] = c;
		if (req == REQ_ECEF_TO_NED) begin
			for (int i = 0; i < 3; i++)
				vec[i] = vec[i] - org[i];
			for (int r = 0; r < 3; r++) begin
				acc = '0;
				for (int k = 0; k < 3; k++)
					acc = acc + rot[r][k] * vec[k];
				res[r] = round_frac(acc);
			end
			res[2] = -res[2];
		end else begin
			vec[2] = -vec[2];
			for (int i = 0; i < 3; i++) begin
				acc = '0;
				for (int k = 0; k < 3; k++)
					acc = acc + rot[k][i] * vec[k];
				res[i] = round_frac(acc) + org[i];
			end
		end
		p.sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (res[i] > CLIP_HI) begin
				res[i] = CLIP_HI;
				p.sat = 1'b1;
			end else if (res[i] < CLIP_LO) begin
				res[i] = CLIP_LO;
				p.sat = 1'b1;
			end
		end
		p.a = coord_t'(res[0]);
		p.b = coord_t'(res[1]);
		p.c = coord_t'(res[2]);
		return p;
	endfunction

	function automatic coord_t pick_coord(input coord_t centre);
		coord_t r;
		coord_t v;
		r = coord_t'({$urandom, $urandom});
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = r;
			4, 5, 6, 7: v = centre + coord_t'($signed(r[24:0]));
			8: begin
				case ($urandom_range(0, 3))
					0: v = COORD_MAX;
					1: v = COORD_MIN;
					2: v = '0;
					default: v = '1;
				endcase
			end
			default: v = coord_t'($signed(r[19:0]));
		endcase
		return v;
	endfunction

	function automatic trig_t q30(input real x);
		return trig_t'(longint'(x * real'(TRIG_ONE)));
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_LIMIT)
			$display("MISMATCH at %0t ns, result %0d: %s", $realtime, results_checked, what);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending.size() == 0) begin
				report_mismatch("result arrived with no item pending");
			end else begin
				oldest = pending.pop_front();
				results_checked++;
				if (saturated)
					sat_results++;
				if (out_a !== oldest.a)
					report_mismatch($sformatf("out_a got %0d want %0d", out_a, oldest.a));
				if (out_b !== oldest.b)
					report_mismatch($sformatf("out_b got %0d want %0d", out_b, oldest.b));
				if (out_c !== oldest.c)
					report_mismatch($sformatf("out_c got %0d want %0d", out_c, oldest.c));
				if (saturated !== oldest.sat)
					report_mismatch($sformatf("saturated got %b want %b", saturated,
						oldest.sat));
			end
		end
	end

	task automatic write_frame_reg(input int idx, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx << ADDR_LSB);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx <= int'(REG_ORIGIN_Z))
			frame_reg[idx] = value & COORD_MASK;
		else if (idx <= int'(REG_COS_LON))
			frame_reg[idx] = value & TRIG_MASK;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Bits above each register's width carry random junk that must be ignored.
	task automatic set_frame(input coord_t ox, oy, oz, input trig_t sla, cla, slo, clo);
		logic [DATA_W-1:0] junk [7];
		foreach (junk[i])
			junk[i] = {$urandom, $urandom};
		write_frame_reg(REG_ORIGIN_X, {junk[0][DATA_W-1:COORD_WIDTH], ox});
		write_frame_reg(REG_ORIGIN_Y, {junk[1][DATA_W-1:COORD_WIDTH], oy});
		write_frame_reg(REG_ORIGIN_Z, {junk[2][DATA_W-1:COORD_WIDTH], oz});
		write_frame_reg(REG_SIN_LAT, {junk[3][DATA_W-1:TRIG_WIDTH], sla});
		write_frame_reg(REG_COS_LAT, {junk[4][DATA_W-1:TRIG_WIDTH], cla});
		write_frame_reg(REG_SIN_LON, {junk[5][DATA_W-1:TRIG_WIDTH], slo});
		write_frame_reg(REG_COS_LON, {junk[6][DATA_W-1:TRIG_WIDTH], clo});
		frames_loaded++;
	endtask

	task automatic load_random_frame();
		real    lat, lon;
		coord_t org [3];
		trig_t  trig [4];
		coord_t ext_c [3] = '{COORD_MAX, COORD_MIN, '0};
		trig_t  ext_t [3] = '{TRIG_ONE, -TRIG_ONE, '0};
		int     kind;
		lat = (real'($urandom_range(0, 180000)) / 1000.0 - 90.0) * DEG;
		lon = (real'($urandom_range(0, 360000)) / 1000.0 - 180.0) * DEG;
		org[0] = coord_t'(longint'(EARTH_MM * $cos(lat) * $cos(lon)));
		org[1] = coord_t'(longint'(EARTH_MM * $cos(lat) * $sin(lon)));
		org[2] = coord_t'(longint'(EARTH_MM * $sin(lat)));
		trig[0] = q30($sin(lat));
		trig[1] = q30($cos(lat));
		trig[2] = q30($sin(lon));
		trig[3] = q30($cos(lon));
		kind = $urandom_range(0, 5);
		if (kind == 3) begin
			foreach (trig[i])
				trig[i] = trig_t'($urandom);
		end else if (kind == 4) begin
			foreach (trig[i])
				trig[i] = ext_t[$urandom_range(0, 2)];
			foreach (org[i])
				org[i] = ext_c[$urandom_range(0, 2)];
		end else if (kind == 5) begin
			foreach (org[i])
				org[i] = coord_t'({$urandom, $urandom});
		end
		set_frame(org[0], org[1], org[2], trig[0], trig[1], trig[2], trig[3]);
	endtask

	task automatic send_position(input req_t req, input coord_t a, b, c);
		int gap;
		gap = $urandom_range(0, gap_limit);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		coord_a <= a;
		coord_b <= b;
		coord_c <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending.push_back(predict_position(req, a, b, c));
		items_sent++;
		if (req == REQ_ECEF_TO_NED)
			ecef_items++;
	endtask

	task automatic send_random_position();
		req_t   req;
		coord_t centre [3];
		req = req_t'($urandom_range(0, 1));
		for (int i = 0; i < 3; i++)
			centre[i] = (req == REQ_ECEF_TO_NED) ? coord_t'(frame_reg[i][COORD_WIDTH-1:0]) : '0;
		send_position(req, pick_coord(centre[0]), pick_coord(centre[1]), pick_coord(centre[2]));
	endtask

	task automatic wait_drain();
		start <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic test_reset_frame();
		gap_limit = 14;
		send_position(REQ_ECEF_TO_NED, '0, '0, '0);
		send_position(REQ_NED_TO_ECEF, '0, '0, '0);
		send_position(REQ_ECEF_TO_NED, COORD_MAX, COORD_MAX, COORD_MAX);
		send_position(REQ_ECEF_TO_NED, COORD_MIN, COORD_MIN, COORD_MIN);
		send_position(REQ_NED_TO_ECEF, COORD_MAX, COORD_MIN, COORD_MAX);
		send_position(REQ_NED_TO_ECEF, COORD_MIN, COORD_MAX, COORD_MIN);
		wait_drain();
	endtask

	task automatic test_frame_extremes();
		set_frame(COORD_MAX, COORD_MAX, COORD_MAX, TRIG_ONE, TRIG_ONE, TRIG_ONE, TRIG_ONE);
		send_position(REQ_ECEF_TO_NED, COORD_MIN, COORD_MIN, COORD_MIN);
		send_position(REQ_NED_TO_ECEF, COORD_MAX, COORD_MAX, COORD_MAX);
		send_position(REQ_NED_TO_ECEF, '0, '0, '0);
		wait_drain();
		set_frame(COORD_MIN, COORD_MIN, COORD_MIN, -TRIG_ONE, -TRIG_ONE, -TRIG_ONE, -TRIG_ONE);
		send_position(REQ_ECEF_TO_NED, COORD_MAX, COORD_MAX, COORD_MAX);
		send_position(REQ_NED_TO_ECEF, COORD_MIN, COORD_MIN, COORD_MIN);
		send_position(REQ_ECEF_TO_NED, '0, '0, '0);
		wait_drain();
	endtask

	// Trig registers beyond plus or minus one are clamped before use.
	task automatic test_trig_clamp();
		set_frame('0, '0, '0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh4000_0001, 32'shBFFF_FFFF);
		send_position(REQ_ECEF_TO_NED, pick_coord('0), pick_coord('0), pick_coord('0));
		send_position(REQ_NED_TO_ECEF, pick_coord('0), pick_coord('0), pick_coord('0));
		send_position(REQ_ECEF_TO_NED, COORD_MAX, '1, COORD_MIN);
		send_position(REQ_NED_TO_ECEF, COORD_MIN, '1, COORD_MAX);
		wait_drain();
	endtask

	// A write above the last register must leave the frame untouched.
	task automatic test_unknown_register();
		set_frame(coord_t'(64'sd2292000000), coord_t'(-64'sd3969000000),
			coord_t'(64'sd4510000000), q30($sin(45.0 * DEG)), q30($cos(45.0 * DEG)),
			q30($sin(-120.0 * DEG)), q30($cos(-120.0 * DEG)));
		write_frame_reg(UNUSED_IDX, {$urandom, $urandom});
		repeat (3)
			send_random_position();
		wait_drain();
	endtask

	task automatic test_drain_pause();
		load_random_frame();
		gap_limit = 3;
		repeat (25)
			send_random_position();
		wait_drain();
		repeat (25)
			send_random_position();
		wait_drain();
	endtask

	task automatic test_random_frames();
		for (int f = 0; f < FRAME_COUNT; f++) begin
			load_random_frame();
			gap_limit = (f % 3 == 1) ? 0 : 14;
			repeat (FRAME_ITEMS)
				send_random_position();
			wait_drain();
		end
	endtask

	initial begin
		foreach (frame_reg[i])
			frame_reg[i] = '0;
		frame_reg[REG_COS_LAT] = 64'd1 << TRIG_FRAC_BITS;
		frame_reg[REG_COS_LON] = 64'd1 << TRIG_FRAC_BITS;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_frame();
		test_frame_extremes();
		test_trig_clamp();
		test_unknown_register();
		test_drain_pause();
		test_random_frames();
		wait_drain();
		repeat (16) @(posedge clk);
		$display("Sent %0d items (%0d ECEF to NED, %0d NED to ECEF) over %0d loaded frames.",
			items_sent, ecef_items, items_sent - ecef_items, frames_loaded);
		$display("Checked %0d results, %0d of them saturated; %0d mismatches.",
			results_checked, sat_results, mismatches);
		if (mismatches == 0 && pending.size() == 0)
			$display("ecef_ned_frame_rotation test passed");
		else
			$display("ecef_ned_frame_rotation test failed");
		$finish;
	end

endmodule
